>>> hw/rtl/bounded_double_ended_queue_defines.svh
// Assertion macros for the queue RTL.
`ifndef BOUNDED_DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define BOUNDED_DOUBLE_ENDED_QUEUE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BDEQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define BDEQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/bdeq_pkg.sv
package bdeq_pkg;

    localparam int CAPACITY_DEF   = 16;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int OPCODE_W = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // Output tdata: value_res then entry_count, padded to whole bytes.
    localparam int M_TDATA_W = ((VALUE_W + COUNT_W + 7) / 8) * 8;

    typedef enum logic [OPCODE_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_LIST       = 3'd4
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_LIST = 1'b1
    } t_state;

endpackage

>>> hw/rtl/bdeq_ram.sv
module bdeq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> hw/rtl/bounded_double_ended_queue.sv
// Bounded double-ended queue held in a ring buffer of CAPACITY entries.
// Input channel s_axis: tuser carries the opcode (push front, push back,
// pop front, pop back, list), tdata the value to push.
// Output channel m_axis: tdata carries the popped or listed value and the
// entry count after the operation, tuser the status, tlast marks the final
// result of an input transaction.
// Push, pop and unused opcodes give one result each, so such transactions
// can follow each other in every cycle while the result stage can take
// them. A pop reads the entry RAM, whose read register runs beside the
// result stage. Each result reaches m_axis through the result stage and
// then the output register. A list blocks the input while it walks the
// queue, with one RAM read per entry while the result stage is free. A
// list of an empty queue gives one empty result.
// Reset empties the queue and clears both result stages; the RAM is not
// cleared, as only held entries are ever read.
// When the receiver stalls, one result waits in the output register and a
// second in the result stage; after that s_axis_tready falls and a list in
// progress pauses without losing an entry.
`include "bounded_double_ended_queue_defines.svh"

module bounded_double_ended_queue #(
    parameter int CAPACITY   = bdeq_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = bdeq_pkg::DATA_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [bdeq_pkg::VALUE_W-1:0]    s_axis_tdata,  // [31:0] value
    input  logic [bdeq_pkg::OPCODE_W-1:0]   s_axis_tuser,  // [2:0] opcode
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [31:0] value_res, [36:32] entry_count, [39:37] zero
    output logic [bdeq_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    output logic [bdeq_pkg::STATUS_W-1:0]   m_axis_tuser,  // [1:0] status
    output logic                            m_axis_tlast
);

    import bdeq_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CW    = (DATA_WIDTH < VALUE_W) ? DATA_WIDTH : VALUE_W;

    t_state             r_state, n_state;
    logic [IDX_W-1:0]   r_front, n_front;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [IDX_W-1:0]   r_idx,   n_idx;

    // Result stage: metadata beside the RAM read register.
    logic               r_a_vld, n_a_vld;
    logic               r_a_zero;
    t_status            r_a_status;
    logic [CNT_W-1:0]   r_a_count;
    logic               r_a_last;

    // Output register.
    logic               r_o_vld, n_o_vld;
    logic [VALUE_W-1:0] r_o_value;
    t_status            r_o_status;
    logic [COUNT_W-1:0] r_o_count;
    logic               r_o_last;

    logic               w_acc, w_full, w_empty, w_a_take, w_a_free, w_list_end;
    t_op                w_op;
    logic [IDX_W-1:0]   w_off, w_slot;
    logic [IDX_W:0]     w_sum;

    logic                  w_wr_en, w_rd_en;
    logic [DATA_WIDTH-1:0] w_wr_data, w_rd_data;

    logic               w_a_load, w_a_zero_in, w_a_last_in;
    t_status            w_a_status_in;
    logic [CNT_W-1:0]   w_a_count_in;

    logic               w_push_ok, w_pop_ok;

    assign w_op       = t_op'(s_axis_tuser);
    assign w_full     = (r_count >= CNT_W'(CAPACITY));
    assign w_empty    = (r_count == '0);
    assign w_a_take   = r_a_vld && (!r_o_vld || m_axis_tready);
    assign w_a_free   = !r_a_vld || w_a_take;
    assign w_list_end = (CNT_W'(r_idx) == r_count - 1'b1);

    assign s_axis_tready = (r_state == S_IDLE) && w_a_free;
    assign w_acc         = s_axis_tvalid && s_axis_tready;

    assign w_push_ok = w_acc && (w_op == OP_PUSH_FRONT || w_op == OP_PUSH_BACK) && !w_full;
    assign w_pop_ok  = w_acc && (w_op == OP_POP_FRONT || w_op == OP_POP_BACK) && !w_empty;

    // Ring address: front plus an offset, wrapped once.
    always_comb begin
        if (r_state == S_LIST) begin
            w_off = r_idx;
        end else begin
            case (w_op)
                OP_PUSH_FRONT: w_off = IDX_W'(CAPACITY - 1);
                OP_PUSH_BACK:  w_off = IDX_W'(r_count);
                OP_POP_BACK:   w_off = IDX_W'(r_count - 1'b1);
                default:       w_off = '0;
            endcase
        end
        w_sum  = {1'b0, r_front} + {1'b0, w_off};
        w_slot = (w_sum >= (IDX_W+1)'(CAPACITY)) ?
                 IDX_W'(w_sum - (IDX_W+1)'(CAPACITY)) : IDX_W'(w_sum);
    end

    assign w_wr_data = DATA_WIDTH'(s_axis_tdata[CW-1:0]);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_acc && w_op == OP_LIST && !w_empty) begin
                    n_state = S_LIST;
                end
            end
            S_LIST: begin
                if (w_a_free && w_list_end) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath control and queue pointers.
    always_comb begin
        n_front       = r_front;
        n_count       = r_count;
        n_idx         = r_idx;
        w_wr_en       = 1'b0;
        w_rd_en       = 1'b0;
        w_a_load      = 1'b0;
        w_a_zero_in   = 1'b1;
        w_a_status_in = ST_OK;
        w_a_count_in  = r_count;
        w_a_last_in   = 1'b1;
        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    case (w_op)
                        OP_PUSH_FRONT, OP_PUSH_BACK: begin
                            w_a_load = 1'b1;
                            if (w_full) begin
                                w_a_status_in = ST_FULL;
                            end else begin
                                w_wr_en      = 1'b1;
                                n_count      = r_count + 1'b1;
                                w_a_count_in = r_count + 1'b1;
                                if (w_op == OP_PUSH_FRONT) begin
                                    n_front = w_slot;
                                end
                            end
                        end
                        OP_POP_FRONT, OP_POP_BACK: begin
                            w_a_load = 1'b1;
                            if (w_empty) begin
                                w_a_status_in = ST_EMPTY;
                            end else begin
                                w_rd_en      = 1'b1;
                                w_a_zero_in  = 1'b0;
                                n_count      = r_count - 1'b1;
                                w_a_count_in = r_count - 1'b1;
                                if (w_op == OP_POP_FRONT) begin
                                    n_front = (r_front == IDX_W'(CAPACITY - 1)) ?
                                              '0 : r_front + 1'b1;
                                end
                            end
                        end
                        OP_LIST: begin
                            n_idx = '0;
                            if (w_empty) begin
                                w_a_load      = 1'b1;
                                w_a_status_in = ST_EMPTY;
                            end
                        end
                        default: w_a_load = 1'b1;
                    endcase
                end
            end
            S_LIST: begin
                if (w_a_free) begin
                    w_rd_en     = 1'b1;
                    w_a_load    = 1'b1;
                    w_a_zero_in = 1'b0;
                    w_a_last_in = w_list_end;
                    n_idx       = r_idx + 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Accesses never overlap on one entry: one transaction is decoded at a
    // time and a write lands before any later read.
    bdeq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_slot),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr ((r_state == S_IDLE && w_op == OP_POP_FRONT) ? r_front : w_slot),
        .o_rd_data (w_rd_data)
    );

    always_comb begin
        n_a_vld = r_a_vld;
        if (w_a_load) begin
            n_a_vld = 1'b1;
        end else if (w_a_take) begin
            n_a_vld = 1'b0;
        end
        n_o_vld = r_o_vld;
        if (w_a_take) begin
            n_o_vld = 1'b1;
        end else if (m_axis_tready) begin
            n_o_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_front <= '0;
            r_count <= '0;
            r_idx   <= '0;
            r_a_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_front <= n_front;
            r_count <= n_count;
            r_idx   <= n_idx;
            r_a_vld <= n_a_vld;
            r_o_vld <= n_o_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_a_load) begin
            r_a_zero   <= w_a_zero_in;
            r_a_status <= w_a_status_in;
            r_a_count  <= w_a_count_in;
            r_a_last   <= w_a_last_in;
        end
        if (w_a_take) begin
            r_o_value  <= r_a_zero ? '0 : VALUE_W'(w_rd_data[CW-1:0]);
            r_o_status <= r_a_status;
            r_o_count  <= COUNT_W'(r_a_count);
            r_o_last   <= r_a_last;
        end
    end

    assign m_axis_tvalid = r_o_vld;
    assign m_axis_tdata  = {{(M_TDATA_W-VALUE_W-COUNT_W){1'b0}}, r_o_count, r_o_value};
    assign m_axis_tuser  = r_o_status;
    assign m_axis_tlast  = r_o_last;

    `BDEQ_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CNT_W'(CAPACITY), "count above capacity")
    `BDEQ_ASSERT_NOW(a_ready_idle, s_axis_tready, r_state == S_IDLE, "input taken during list walk")
    `BDEQ_ASSERT_NEXT(a_push_count, w_push_ok, r_count == $past(r_count) + 1'b1, "push lost")
    `BDEQ_ASSERT_NEXT(a_pop_count, w_pop_ok, r_count == $past(r_count) - 1'b1, "pop lost")

endmodule
